### hw/rtl/usc_pkg.sv
// usc_pkg: constants, types and the divide step for the seconds-to-calendar block
// constant divisors use reciprocal multiplies whose scale is chosen so the quotient is exact
// no dependencies
package usc_pkg;

  // port widths
  localparam int unsigned SECS_W  = 40;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  localparam int unsigned PIPE_DEPTH = 14;

  // calendar constants
  localparam int unsigned SECS_PER_DAY     = 86400;
  localparam int unsigned DAY_SHIFT        = 7;
  localparam int unsigned DAY_ODD          = SECS_PER_DAY >> DAY_SHIFT;
  localparam int unsigned SECS_PER_HOUR    = 3600;
  localparam int unsigned SECS_PER_MIN     = 60;
  localparam int unsigned DAYS_PER_WEEK    = 7;
  localparam int unsigned WEEKDAY_EPOCH    = 4;
  localparam int unsigned EPOCH_SHIFT_DAYS = 719468;
  localparam int unsigned DAYS_PER_ERA     = 146097;
  localparam int unsigned DAYS_ERA_LAST    = 146096;
  localparam int unsigned YEARS_PER_ERA    = 400;
  localparam int unsigned DAYS_PER_YEAR    = 365;
  localparam int unsigned MP_SPAN          = 153;
  localparam int unsigned MP_PARTS         = 5;
  localparam int unsigned MP_ROUND         = 2;
  localparam int unsigned MP_JANUARY       = 10;
  localparam int unsigned MONTH_MARCH      = 3;
  localparam int unsigned MONTHS_PER_YEAR  = 12;
  localparam int unsigned MONTH_FEB        = 2;

  // internal widths
  localparam int unsigned DAYS_W = 24;
  localparam int unsigned SOD_W  = 17;
  localparam int unsigned Z_W    = 25;
  localparam int unsigned ERA_W  = 7;
  localparam int unsigned DOE_W  = 18;
  localparam int unsigned YOE_W  = 9;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned S2_W   = 12;
  localparam int unsigned MP_W   = 4;
  localparam int unsigned V_W    = 11;

  // reciprocal multipliers: shift = operand bits + divisor bits, factor = 2^shift / d + 1
  localparam int unsigned ERA_SH  = 43;
  localparam logic [25:0] ERA_MUL = 26'(((64'd1 << ERA_SH) / DAYS_PER_ERA) + 1);
  localparam int unsigned WK_SH   = 28;
  localparam logic [25:0] WK_MUL  = 26'(((64'd1 << WK_SH) / DAYS_PER_WEEK) + 1);
  localparam int unsigned HR_SH   = 29;
  localparam logic [17:0] HR_MUL  = 18'(((64'd1 << HR_SH) / SECS_PER_HOUR) + 1);
  localparam int unsigned MN_SH   = 18;
  localparam logic [12:0] MN_MUL  = 13'(((64'd1 << MN_SH) / SECS_PER_MIN) + 1);
  localparam int unsigned Y4_SH   = 29;
  localparam logic [18:0] Y4_MUL  = 19'(((64'd1 << Y4_SH) / 1460) + 1);
  localparam int unsigned Y100_SH = 34;
  localparam logic [18:0] Y100_MUL = 19'(((64'd1 << Y100_SH) / 36524) + 1);
  localparam int unsigned Y365_SH = 27;
  localparam logic [18:0] Y365_MUL = 19'(((64'd1 << Y365_SH) / DAYS_PER_YEAR) + 1);
  localparam int unsigned C100_SH = 16;
  localparam logic [9:0]  C100_MUL = 10'(((64'd1 << C100_SH) / 100) + 1);
  localparam int unsigned MP_SH   = 19;
  localparam logic [11:0] MP_MUL  = 12'(((64'd1 << MP_SH) / MP_SPAN) + 1);
  localparam int unsigned D5_SH   = 14;
  localparam logic [11:0] D5_MUL  = 12'(((64'd1 << D5_SH) / MP_PARTS) + 1);

  typedef struct packed {
    logic [7:0] q;
    logic [9:0] rem;
  } div_step_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } tod_t;

  // eight restoring steps of a long division by the odd part of a day length
  function automatic div_step_t div_odd_step8(input logic [9:0] rem_in, input logic [7:0] bits);
    div_step_t  res;
    logic [10:0] acc;
    logic [9:0]  rem;
    rem = rem_in;
    res.q = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {rem, bits[i]};
      if (acc >= 11'(DAY_ODD)) begin
        acc = acc - 11'(DAY_ODD);
        res.q[i] = 1'b1;
      end
      rem = acc[9:0];
    end
    res.rem = rem;
    return res;
  endfunction

endpackage

### hw/rtl/unix_seconds_to_calendar.sv
// unix_seconds_to_calendar: splits a 40-bit count of seconds since 1970 into date, time, weekday
// depends on usc_pkg for constants, reciprocal factors and the divide step
//
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_unix_seconds     | timestamp in
//   out     | out_valid, out_stall, out_year .. out_weekday | calendar fields out
//
// 14-stage pipeline, one transaction per cycle while out_stall is low; out_valid rises when a
// transaction reaches stage 14, and the result is taken at an edge on which out_stall is low.
// stages 1-3 divide by 86400 with 8 long-division steps each; later divisions use reciprocal multiplies.
// each stage moves when it is empty or the one after it moves, so bubbles close up under stall.
// rst_n clears the valid bits only; the data registers are not reset.
module unix_seconds_to_calendar (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [usc_pkg::SECS_W-1:0]   in_unix_seconds,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [usc_pkg::YEAR_W-1:0]   out_year,
  output logic [usc_pkg::MONTH_W-1:0]  out_month,
  output logic [usc_pkg::DOM_W-1:0]    out_day_of_month,
  output logic [usc_pkg::HOUR_W-1:0]   out_hour,
  output logic [usc_pkg::MIN_W-1:0]    out_minute,
  output logic [usc_pkg::SEC_W-1:0]    out_second,
  output logic [usc_pkg::WDAY_W-1:0]   out_weekday
);
  import usc_pkg::*;

  logic [PIPE_DEPTH:1] v_r;
  logic [PIPE_DEPTH:1] adv;

  // stages 1-3: days and second of day
  logic [7:0]        q1_r;
  logic [9:0]        rem1_r;
  logic [15:0]       lo1_r;
  logic [6:0]        sl1_r;
  logic [15:0]       q2_r;
  logic [9:0]        rem2_r;
  logic [7:0]        lo2_r;
  logic [6:0]        sl2_r;
  logic [DAYS_W-1:0] days3_r;
  logic [SOD_W-1:0]  sod3_r;
  div_step_t         d1_nxt, d2_nxt, d3_nxt;

  // stages 4-7
  logic [Z_W-1:0]    z4_r, wk4_r, z5_r, wk5_r;
  logic [34:0]       hrp4_r, hrp4_nxt;
  logic [SOD_W-1:0]  sod4_r;
  logic [50:0]       erap5_r, erap5_nxt, wkp5_r, wkp5_nxt;
  logic [HOUR_W-1:0] hour5_r, hour5_nxt, hour6_r;
  logic [S2_W-1:0]   s2_5_r, s2_5_nxt, s2_6_r;
  logic [ERA_W-1:0]  era_r [6:10];
  logic [ERA_W-1:0]  era6_nxt;
  logic [DOE_W-1:0]  doe_r [6:10];
  logic [DOE_W-1:0]  doe6_nxt;
  logic [WDAY_W-1:0] wd6_r, wd6_nxt;
  logic [24:0]       mnp6_r, mnp6_nxt;
  tod_t              tod_r [7:14];
  tod_t              tod7_nxt;
  logic [36:0]       y4p7_r, y4p7_nxt, y100p7_r, y100p7_nxt;

  // stages 8-14
  logic [DOE_W-1:0]  n8_r, n8_nxt;
  logic [36:0]       y365p9_r, y365p9_nxt;
  logic [YOE_W-1:0]  yoe10_r;
  logic [18:0]       c100_prod;
  logic [DOE_W-1:0]  yd11;
  logic [DOY_W-1:0]  doy_r [11:13];
  logic [DOY_W-1:0]  doy11_nxt;
  logic [YEAR_W-1:0] ybase_r [11:13];
  logic [YEAR_W-1:0] ybase11_nxt;
  logic [V_W-1:0]    v12;
  logic [22:0]       mpp12_r, mpp12_nxt;
  logic [MP_W-1:0]   mp13_r, mp13_nxt;
  logic [V_W-1:0]    w13;
  logic [22:0]       d5p13_r, d5p13_nxt;
  logic [DOY_W-1:0]  dd14;
  logic [YEAR_W-1:0]  year14_r, year14_nxt;
  logic [MONTH_W-1:0] month14_r, month14_nxt;
  logic [DOM_W-1:0]   dom14_r, dom14_nxt;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || !out_stall;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = v_r[PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    // seconds / 86400 = (seconds >> 7) / 675; the top nine bits are already below 675
    d1_nxt = div_odd_step8({1'b0, in_unix_seconds[39:31]}, in_unix_seconds[30:23]);
    d2_nxt = div_odd_step8(rem1_r, lo1_r[15:8]);
    d3_nxt = div_odd_step8(rem2_r, lo2_r);

    hrp4_nxt = 35'(sod3_r) * 35'(HR_MUL);

    erap5_nxt = 51'(z4_r) * 51'(ERA_MUL);
    wkp5_nxt  = 51'(wk4_r) * 51'(WK_MUL);
    hour5_nxt = hrp4_r[HR_SH +: HOUR_W];
    s2_5_nxt  = S2_W'(sod4_r - SOD_W'(hour5_nxt) * SOD_W'(SECS_PER_HOUR));

    era6_nxt = erap5_r[ERA_SH +: ERA_W];
    doe6_nxt = DOE_W'(z5_r - Z_W'(era6_nxt) * Z_W'(DAYS_PER_ERA));
    wd6_nxt  = WDAY_W'(wk5_r - Z_W'(wkp5_r[WK_SH +: 22]) * Z_W'(DAYS_PER_WEEK));
    mnp6_nxt = 25'(s2_5_r) * 25'(MN_MUL);

    tod7_nxt.hour    = hour6_r;
    tod7_nxt.minute  = mnp6_r[MN_SH +: MIN_W];
    tod7_nxt.second  = SEC_W'(s2_6_r - S2_W'(tod7_nxt.minute) * S2_W'(SECS_PER_MIN));
    tod7_nxt.weekday = wd6_r;
    y4p7_nxt   = 37'(doe_r[6]) * 37'(Y4_MUL);
    y100p7_nxt = 37'(doe_r[6]) * 37'(Y100_MUL);

    // last day of an era counts as a leap day of year 399
    n8_nxt = doe_r[7] - DOE_W'(y4p7_r[Y4_SH +: 7]) + DOE_W'(y100p7_r[Y100_SH +: 3])
             - DOE_W'(doe_r[7] == DOE_W'(DAYS_ERA_LAST));

    y365p9_nxt = 37'(n8_r) * 37'(Y365_MUL);

    c100_prod   = 19'(yoe10_r) * 19'(C100_MUL);
    yd11        = DOE_W'(yoe10_r) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe10_r >> 2)
                  - DOE_W'(c100_prod[C100_SH +: 2]);
    doy11_nxt   = DOY_W'(doe_r[10] - yd11);
    ybase11_nxt = YEAR_W'(yoe10_r) + YEAR_W'(era_r[10]) * YEAR_W'(YEARS_PER_ERA);

    // march-based month index
    v12       = V_W'(doy_r[11]) * V_W'(MP_PARTS) + V_W'(MP_ROUND);
    mpp12_nxt = 23'(v12) * 23'(MP_MUL);

    mp13_nxt  = mpp12_r[MP_SH +: MP_W];
    w13       = V_W'(mp13_nxt) * V_W'(MP_SPAN) + V_W'(MP_ROUND);
    d5p13_nxt = 23'(w13) * 23'(D5_MUL);

    dd14        = d5p13_r[D5_SH +: DOY_W];
    dom14_nxt   = DOM_W'(doy_r[13] - dd14 + DOY_W'(1));
    month14_nxt = mp13_r + MONTH_W'(MONTH_MARCH)
                  - ((mp13_r >= MP_W'(MP_JANUARY)) ? MONTH_W'(MONTHS_PER_YEAR) : '0);
    year14_nxt  = ybase_r[13] + YEAR_W'(month14_nxt <= MONTH_W'(MONTH_FEB));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      q1_r   <= d1_nxt.q;
      rem1_r <= d1_nxt.rem;
      lo1_r  <= in_unix_seconds[22:7];
      sl1_r  <= in_unix_seconds[6:0];
    end
    if (adv[2]) begin
      q2_r   <= {q1_r, d2_nxt.q};
      rem2_r <= d2_nxt.rem;
      lo2_r  <= lo1_r[7:0];
      sl2_r  <= sl1_r;
    end
    if (adv[3]) begin
      days3_r <= {q2_r, d3_nxt.q};
      sod3_r  <= {d3_nxt.rem, sl2_r};
    end
    if (adv[4]) begin
      z4_r   <= Z_W'(days3_r) + Z_W'(EPOCH_SHIFT_DAYS);
      wk4_r  <= Z_W'(days3_r) + Z_W'(WEEKDAY_EPOCH);
      hrp4_r <= hrp4_nxt;
      sod4_r <= sod3_r;
    end
    if (adv[5]) begin
      erap5_r <= erap5_nxt;
      z5_r    <= z4_r;
      wkp5_r  <= wkp5_nxt;
      wk5_r   <= wk4_r;
      hour5_r <= hour5_nxt;
      s2_5_r  <= s2_5_nxt;
    end
    if (adv[6]) begin
      era_r[6] <= era6_nxt;
      doe_r[6] <= doe6_nxt;
      wd6_r    <= wd6_nxt;
      hour6_r  <= hour5_r;
      mnp6_r   <= mnp6_nxt;
      s2_6_r   <= s2_5_r;
    end
    if (adv[7]) begin
      tod_r[7] <= tod7_nxt;
      y4p7_r   <= y4p7_nxt;
      y100p7_r <= y100p7_nxt;
    end
    for (int k = 7; k <= 10; k++) begin
      if (adv[k]) begin
        era_r[k] <= era_r[k-1];
        doe_r[k] <= doe_r[k-1];
      end
    end
    for (int k = 8; k <= PIPE_DEPTH; k++) begin
      if (adv[k]) begin
        tod_r[k] <= tod_r[k-1];
      end
    end
    if (adv[8]) begin
      n8_r <= n8_nxt;
    end
    if (adv[9]) begin
      y365p9_r <= y365p9_nxt;
    end
    if (adv[10]) begin
      yoe10_r <= y365p9_r[Y365_SH +: YOE_W];
    end
    if (adv[11]) begin
      doy_r[11]   <= doy11_nxt;
      ybase_r[11] <= ybase11_nxt;
    end
    for (int k = 12; k <= 13; k++) begin
      if (adv[k]) begin
        doy_r[k]   <= doy_r[k-1];
        ybase_r[k] <= ybase_r[k-1];
      end
    end
    if (adv[12]) begin
      mpp12_r <= mpp12_nxt;
    end
    if (adv[13]) begin
      mp13_r  <= mp13_nxt;
      d5p13_r <= d5p13_nxt;
    end
    if (adv[14]) begin
      year14_r  <= year14_nxt;
      month14_r <= month14_nxt;
      dom14_r   <= dom14_nxt;
    end
  end

  assign out_year         = year14_r;
  assign out_month        = month14_r;
  assign out_day_of_month = dom14_r;
  assign out_hour         = tod_r[PIPE_DEPTH].hour;
  assign out_minute       = tod_r[PIPE_DEPTH].minute;
  assign out_second       = tod_r[PIPE_DEPTH].second;
  assign out_weekday      = tod_r[PIPE_DEPTH].weekday;

  // stall at the input only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1])
    else $error("accepted transaction not captured in first stage");

  a_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= MONTH_W'(1) &&
                   out_month <= MONTH_W'(MONTHS_PER_YEAR) &&
                   out_day_of_month != '0))
    else $error("month or day out of range");

  a_tod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < HOUR_W'(24) && out_minute < MIN_W'(SECS_PER_MIN) &&
                   out_second < SEC_W'(SECS_PER_MIN) &&
                   out_weekday < WDAY_W'(DAYS_PER_WEEK)))
    else $error("time of day or weekday out of range");

endmodule
